### hdl/rgb_color_effect_filter_assert.svh
// Assertion macros for the RGB colour effect filter.
// Expects clk and rst_n in the scope of the including module.
`ifndef RGB_COLOR_EFFECT_FILTER_ASSERT_SVH
`define RGB_COLOR_EFFECT_FILTER_ASSERT_SVH

// Checked only out of reset.
`define RCEF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RCEF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/rcef_pkg.sv
// Types and constants for the RGB colour effect filter.
// No dependencies.
package rcef_pkg;

  localparam int CH_W   = 8;
  localparam int CNT_W  = 10;
  localparam int SIDE_W = 11;
  localparam int ACC_W  = 20;

  localparam logic [SIDE_W-1:0] MAX_SIDE     = 11'd1024;
  localparam logic [SIDE_W-1:0] SIDE_RESET   = 11'd400;

  typedef enum logic [1:0] {
    MODE_COPY   = 2'd0,
    MODE_GRAY   = 2'd1,
    MODE_SEPIA  = 2'd2,
    MODE_INVERT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_EFFECT_MODE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Sepia matrix, Q0.10; row is the output channel, column the input channel
  localparam logic [9:0] SEPIA_Q10 [3][3] = '{
    '{10'd402, 10'd787, 10'd194},
    '{10'd357, 10'd702, 10'd172},
    '{10'd279, 10'd547, 10'd134}
  };

  // Divide by 3 for sums up to 765: (s * 683) >> 11 is exact
  localparam logic [9:0] GRAY_RECIP = 10'd683;
  localparam int         GRAY_SHIFT = 11;

endpackage

### hdl/rcef_in_if.sv
// Input pixel channel: valid/ready with one RGB word.
// Depends on rcef_pkg.
interface rcef_in_if import rcef_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

### hdl/rcef_out_if.sv
// Result channel: valid/ready with coordinates and transformed colour.
// Depends on rcef_pkg.
interface rcef_out_if import rcef_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] pixel_x;
  logic [CNT_W-1:0] pixel_y;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;

  modport source (output valid, output pixel_x, output pixel_y,
                  output out_red, output out_green, output out_blue,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y,
                  input out_red, input out_green, input out_blue,
                  output ready);
endinterface

### hdl/rgb_color_effect_filter.sv
// RGB colour effect filter. Takes one pixel word per clock in raster order and
// returns it with its column/row coordinates and the selected effect applied
// (copy, grayscale average, sepia saturated at 255, or invert). Throughput is
// one pixel per cycle while out_px.ready holds high; each pixel passes through
// the input register and the result register around the effect datapath.
// in_px.ready follows out_px.ready combinationally when both registers are full.
// Width and height of 0 act as 1, above 1024 act as 1024; configuration writes
// keep the coordinate counters and should be made while no pixel is in flight.
// Depends on rcef_pkg, rcef_in_if, rcef_out_if, rcef_effect and the assert header.
module rgb_color_effect_filter import rcef_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [SIDE_W-1:0] cfg_data,
  rcef_in_if.sink           in_px,
  rcef_out_if.source        out_px
);

  `include "rgb_color_effect_filter_assert.svh"

  mode_t             mode_r;
  logic [SIDE_W-1:0] width_r;
  logic [SIDE_W-1:0] height_r;

  logic [CNT_W-1:0]  col_r, col_nxt, col_inc;
  logic [CNT_W-1:0]  row_r, row_nxt, row_inc;
  logic [SIDE_W-1:0] w_eff, h_eff;
  logic              col_wrap, row_wrap;

  logic              s1_v_r, s1_v_nxt;
  rgb_t              s1_px_r;
  mode_t             s1_mode_r;
  logic [CNT_W-1:0]  s1_x_r, s1_y_r;

  logic              out_v_r, out_v_nxt;
  rgb_t              out_px_r;
  logic [CNT_W-1:0]  out_x_r, out_y_r;

  rgb_t              fx_res;
  logic              in_acc, s2_load;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SEPIA;
      width_r  <= SIDE_RESET;
      height_r <= SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EFFECT_MODE:  mode_r   <= mode_t'(cfg_data[1:0]);
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster counters
  always_comb begin
    w_eff = (width_r == '0) ? SIDE_W'(1) : (width_r > MAX_SIDE) ? MAX_SIDE : width_r;
    h_eff = (height_r == '0) ? SIDE_W'(1) : (height_r > MAX_SIDE) ? MAX_SIDE : height_r;

    col_inc  = col_r + 1'b1;
    row_inc  = row_r + 1'b1;
    col_wrap = (col_inc == '0) || ({1'b0, col_inc} >= w_eff);
    row_wrap = (row_inc == '0) || ({1'b0, row_inc} >= h_eff);

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      col_nxt = col_wrap ? '0 : col_inc;
      if (col_wrap) begin
        row_nxt = row_wrap ? '0 : row_inc;
      end
    end
  end

  // handshake
  assign s2_load      = s1_v_r && (!out_v_r || out_px.ready);
  assign in_px.ready  = !s1_v_r || !out_v_r || out_px.ready;
  assign in_acc       = in_px.valid && in_px.ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s2_load) begin
      s1_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (s2_load) begin
      out_v_nxt = 1'b1;
    end else if (out_px.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= '{red: in_px.in_red, green: in_px.in_green, blue: in_px.in_blue};
      s1_mode_r <= mode_r;
      s1_x_r    <= col_r;
      s1_y_r    <= row_r;
    end
  end

  rcef_effect u_effect (
    .mode (s1_mode_r),
    .px   (s1_px_r),
    .res  (fx_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_px_r <= fx_res;
      out_x_r  <= s1_x_r;
      out_y_r  <= s1_y_r;
    end
  end

  assign out_px.valid     = out_v_r;
  assign out_px.pixel_x   = out_x_r;
  assign out_px.pixel_y   = out_y_r;
  assign out_px.out_red   = out_px_r.red;
  assign out_px.out_green = out_px_r.green;
  assign out_px.out_blue  = out_px_r.blue;

  `RCEF_ASSERT(a_in_lands, rst_n && in_acc |=> s1_v_r, "accepted pixel word not held in input register")
  `RCEF_ASSERT(a_s1_holds, rst_n && s1_v_r && !s2_load |=> s1_v_r, "pixel word dropped from input register")
  `RCEF_ASSERT(a_col_step, rst_n && in_acc && !col_wrap |=> col_r == $past(col_inc), "column counter did not step")
  `RCEF_ASSERT(a_row_hold, rst_n && !(in_acc && col_wrap) |=> $stable(row_r), "row counter moved without column wrap")
  `RCEF_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !s1_v_r && !out_v_r, "pipeline valid set after reset")

endmodule

### hdl/rcef_effect.sv
// Colour effect datapath: copy, grayscale, sepia or invert of one pixel.
// Purely combinational; depends on rcef_pkg.
module rcef_effect import rcef_pkg::*; (
  input  mode_t mode,
  input  rgb_t  px,
  output rgb_t  res
);

  logic [CH_W-1:0]   ch    [3];
  logic [CH_W-1:0]   sep   [3];
  logic [ACC_W-1:0]  acc   [3];
  logic [9:0]        sum3;
  logic [ACC_W-1:0]  gray_prod;
  logic [CH_W-1:0]   gray;

  always_comb begin
    ch[0] = px.red;
    ch[1] = px.green;
    ch[2] = px.blue;

    sum3      = {2'b00, ch[0]} + {2'b00, ch[1]} + {2'b00, ch[2]};
    gray_prod = ACC_W'(sum3) * ACC_W'(GRAY_RECIP);
    gray      = gray_prod[GRAY_SHIFT+CH_W-1:GRAY_SHIFT];

    for (int k = 0; k < 3; k++) begin
      acc[k] = ACC_W'(SEPIA_Q10[k][0]) * ACC_W'(ch[0])
             + ACC_W'(SEPIA_Q10[k][1]) * ACC_W'(ch[1])
             + ACC_W'(SEPIA_Q10[k][2]) * ACC_W'(ch[2]);
      // >> 10 then saturate at 255
      sep[k] = (acc[k][ACC_W-1:10+CH_W] != '0) ? {CH_W{1'b1}} : acc[k][10+CH_W-1:10];
    end

    case (mode)
      MODE_GRAY:   res = '{red: gray, green: gray, blue: gray};
      MODE_SEPIA:  res = '{red: sep[0], green: sep[1], blue: sep[2]};
      MODE_INVERT: res = '{red: ~ch[0], green: ~ch[1], blue: ~ch[2]};
      default:     res = px;
    endcase
  end

endmodule
